FILE: rtl/wohi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wohi_pkg: shared types and constants for the odometry heading integrator
// Sequencer states, angle and position formats, and the CORDIC arctangents.
// ----------------------------------------------------------------------------
package wohi_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WRAP,
        ST_FOLD,
        ST_ROTATE,
        ST_MUL_M,
        ST_MUL_SH,
        ST_MUL_SL,
        ST_STEP_S,
        ST_ACC_S,
        ST_MUL_CH,
        ST_MUL_CL,
        ST_STEP_C,
        ST_ACC_C,
        ST_FINISH
    } state_t;

    // angle in Q30 radians, wide enough for the unreduced heading
    localparam int ANG_W = 40;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t ANG_PI         = 40'sd3373259426;
    localparam ang_t ANG_TWO_PI     = 40'sd6746518852;
    localparam ang_t ANG_HALF_PI    = 40'sd1686629713;
    // 32 turns, lifts any negative heading above zero
    localparam ang_t ANG_NEG_OFFSET = 40'sd215888603264;

    localparam logic [2:0] RED_LAST = 3'd5;

    localparam int TRIG_W = 34;
    typedef logic signed [TRIG_W-1:0] trig_t;
    localparam trig_t CORDIC_X0 = 34'sd652032874;

    localparam int POS_W = 48;
    typedef logic signed [POS_W-1:0] pos_t;
    localparam pos_t POS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam pos_t POS_MIN = 48'sh8000_0000_0000;

    localparam int MAG_W = 50;
    localparam logic [MAG_W-1:0] MAG_CAP = 50'h2_0000_0000_0000;

    localparam int STEP_W = 51;
    typedef logic signed [STEP_W-1:0] step_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/wheel_odometry_heading_integrator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_odometry_heading_integrator_top: differential dead reckoning
// Encoder deltas, CORDIC sine/cosine of the heading, scaled and saturating
// accumulation of the X and Y positions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word of right count, left
//   count and heading. in_ready is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready) returns negated X and plain Y.
//   Configuration channel (cfg_valid/cfg_ready) writes scale_k; always ready,
//   write it only while no word is in flight.
// Sequence: the result follows acceptance after six angle reduction steps,
//   one CORDIC iteration per cycle on a shared add/shift unit, and five
//   products on one shared 32x32 multiplier; a new word is taken only once
//   the last result has left the sequencer.
// Stall: a result waits in the output register; the next word is accepted
//   meanwhile and its result holds in the last step until the register frees.
// Reset: clears positions and previous counts, scale_k returns to 57649.
// ----------------------------------------------------------------------------
module wheel_odometry_heading_integrator_top
    import wohi_pkg::*;
#(
    parameter int COUNT_BITS   = 32,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] count_right,
    input  logic signed [31:0] count_left,
    input  logic signed [23:0] heading,

    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] pos_x,
    output logic signed [47:0] pos_y,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int IW = $clog2(CORDIC_STEPS);

    state_t state_reg, state_next;

    logic [31:0]                  scale_k_reg;
    logic [COUNT_BITS-1:0]        prev_right_reg;
    logic [COUNT_BITS-1:0]        prev_left_reg;
    logic signed [COUNT_BITS-1:0] dr_reg;
    logic signed [COUNT_BITS-1:0] dl_reg;
    logic signed [COUNT_BITS:0]   sum_reg;
    logic [31:0]                  am_reg;
    logic                         avg_neg_reg;

    ang_t                         a_reg;
    logic [2:0]                   red_k_reg;
    logic                         neg_reg;
    trig_t                        x_reg;
    trig_t                        y_reg;
    logic [IW-1:0]                i_reg;

    logic [63:0]                  prod_reg;
    logic [63:0]                  m_reg;
    logic [63:0]                  hi_reg;
    step_t                        step_reg;
    pos_t                         acc_x_reg;
    pos_t                         acc_y_reg;

    logic                         out_valid_reg;
    pos_t                         pos_x_reg;
    pos_t                         pos_y_reg;

    // combinational datapath
    logic [COUNT_BITS-1:0]        dr_new;
    logic [COUNT_BITS-1:0]        dl_new;
    ang_t                         a_load;
    ang_t                         red_term;
    logic [COUNT_BITS:0]          sum_abs;
    trig_t                        x_sh;
    trig_t                        y_sh;
    ang_t                         atan_val;
    trig_t                        x_abs;
    trig_t                        y_abs;
    logic                         sign_s;
    logic                         sign_c;
    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  prod_next;
    logic [33:0]                  lo_part;
    logic                         cap;
    logic [MAG_W-1:0]             mag_sum;
    logic [MAG_W-1:0]             mag;
    logic                         step_neg;
    step_t                        step_val;
    pos_t                         acc_src;
    logic signed [POS_W+3:0]      acc_sum;
    pos_t                         acc_sat;
    logic                         out_free;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        dr_new   = count_right[COUNT_BITS-1:0] - prev_right_reg;
        dl_new   = prev_left_reg - count_left[COUNT_BITS-1:0];
        a_load   = (ang_t'(heading) <<< 14) + (heading[23] ? ANG_NEG_OFFSET : ang_t'(0));
        red_term = ANG_TWO_PI <<< red_k_reg;
        // truncation toward zero: magnitude of the average is |sum| >> 1
        sum_abs  = sum_reg[COUNT_BITS] ? (COUNT_BITS+1)'(0) - sum_reg : sum_reg;

        x_sh     = x_reg >>> i_reg;
        y_sh     = y_reg >>> i_reg;
        atan_val = {8'b0, atan_q30(5'(i_reg))};

        x_abs    = x_reg[TRIG_W-1] ? -x_reg : x_reg;
        y_abs    = y_reg[TRIG_W-1] ? -y_reg : y_reg;
        sign_s   = y_reg[TRIG_W-1] ^ neg_reg;
        sign_c   = x_reg[TRIG_W-1] ^ neg_reg;

        prod_next = mul_a * mul_b;

        lo_part  = prod_reg[63:30];
        cap      = |hi_reg[63:47];
        mag_sum  = MAG_W'({hi_reg[46:0], 2'b00}) + MAG_W'(lo_part);
        mag      = (cap || mag_sum > MAG_CAP) ? MAG_CAP : mag_sum;
        step_neg = avg_neg_reg ^ ((state_reg == ST_STEP_S) ? sign_s : sign_c);
        step_val = step_neg ? -step_t'(mag) : step_t'(mag);

        acc_src  = (state_reg == ST_ACC_S) ? acc_x_reg : acc_y_reg;
        acc_sum  = (POS_W+4)'(acc_src) + (POS_W+4)'(step_reg);
        if (acc_sum > (POS_W+4)'(POS_MAX))
            acc_sat = POS_MAX;
        else if (acc_sum < (POS_W+4)'(POS_MIN))
            acc_sat = POS_MIN;
        else
            acc_sat = acc_sum[POS_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_REDUCE;
            ST_REDUCE: if (red_k_reg == 3'd0) state_next = ST_WRAP;
            ST_WRAP:   state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_ROTATE;
            ST_ROTATE: if (i_reg == IW'(CORDIC_STEPS - 1)) state_next = ST_MUL_M;
            ST_MUL_M:  state_next = ST_MUL_SH;
            ST_MUL_SH: state_next = ST_MUL_SL;
            ST_MUL_SL: state_next = ST_STEP_S;
            ST_STEP_S: state_next = ST_ACC_S;
            ST_ACC_S:  state_next = ST_MUL_CH;
            ST_MUL_CH: state_next = ST_MUL_CL;
            ST_MUL_CL: state_next = ST_STEP_C;
            ST_STEP_C: state_next = ST_ACC_C;
            ST_ACC_C:  state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake and multiplier operands
    always_comb
    begin
        in_ready = 1'b0;
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_MUL_M:
            begin
                mul_a = am_reg;
                mul_b = scale_k_reg;
            end
            ST_MUL_SH:
            begin
                mul_a = prod_reg[63:32];
                mul_b = y_abs[31:0];
            end
            ST_MUL_SL:
            begin
                mul_a = m_reg[31:0];
                mul_b = y_abs[31:0];
            end
            ST_MUL_CH:
            begin
                mul_a = m_reg[63:32];
                mul_b = x_abs[31:0];
            end
            ST_MUL_CL:
            begin
                mul_a = m_reg[31:0];
                mul_b = x_abs[31:0];
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scale_k_reg    <= 32'd57649;
            prev_right_reg <= '0;
            prev_left_reg  <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
            red_k_reg      <= '0;
            i_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                scale_k_reg <= cfg_data;
            if (state_reg == ST_FINISH && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        dr_reg         <= dr_new;
                        dl_reg         <= dl_new;
                        prev_right_reg <= count_right[COUNT_BITS-1:0];
                        prev_left_reg  <= count_left[COUNT_BITS-1:0];
                        a_reg          <= a_load;
                        red_k_reg      <= RED_LAST;
                    end
                end
                ST_REDUCE:
                begin
                    sum_reg <= (COUNT_BITS+1)'(dr_reg) + (COUNT_BITS+1)'(dl_reg);
                    if (a_reg >= red_term)
                        a_reg <= a_reg - red_term;
                    red_k_reg <= red_k_reg - 3'd1;
                end
                ST_WRAP:
                begin
                    am_reg      <= 32'(sum_abs[COUNT_BITS:1]);
                    avg_neg_reg <= sum_reg[COUNT_BITS];
                    if (a_reg > ANG_PI)
                        a_reg <= a_reg - ANG_TWO_PI;
                end
                ST_FOLD:
                begin
                    // fold into the right half plane, negate both results
                    neg_reg <= (a_reg > ANG_HALF_PI) || (a_reg < -ANG_HALF_PI);
                    if (a_reg > ANG_HALF_PI)
                        a_reg <= a_reg - ANG_PI;
                    else if (a_reg < -ANG_HALF_PI)
                        a_reg <= a_reg + ANG_PI;
                    x_reg <= CORDIC_X0;
                    y_reg <= '0;
                    i_reg <= '0;
                end
                ST_ROTATE:
                begin
                    if (a_reg >= 0)
                    begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        a_reg <= a_reg - atan_val;
                    end
                    else
                    begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        a_reg <= a_reg + atan_val;
                    end
                    i_reg <= i_reg + IW'(1);
                end
                ST_MUL_SH: m_reg  <= prod_reg;
                ST_MUL_SL: hi_reg <= prod_reg;
                ST_STEP_S: step_reg  <= step_val;
                ST_ACC_S:  acc_x_reg <= acc_sat;
                ST_MUL_CL: hi_reg <= prod_reg;
                ST_STEP_C: step_reg  <= step_val;
                ST_ACC_C:  acc_y_reg <= acc_sat;
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        pos_x_reg <= (acc_x_reg == POS_MIN) ? POS_MAX : -acc_x_reg;
                        pos_y_reg <= acc_y_reg;
                    end
                end
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    // shared multiplier, product registered every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule
